[hdl/sfd_pkg.sv]
// ----------------------------------------------------------------------------
// sfd_pkg
// Shared types and constants for the S.BUS frame decoder.
// ----------------------------------------------------------------------------
package sfd_pkg;

  localparam logic [7:0]  START_BYTE    = 8'h0F;
  localparam int          PAY_BYTES     = 22;
  localparam int          PAY_W         = PAY_BYTES * 8;
  localparam int          CH_W          = 11;
  localparam int          MAX_CHANNELS  = 16;
  localparam logic [4:0]  CNT_PAY_FIRST = 5'd1;
  localparam logic [4:0]  CNT_PAY_LAST  = 5'd22;
  localparam logic [4:0]  CNT_FLAGS     = 5'd23;
  localparam logic [4:0]  CNT_FRAME_END = 5'd24;
  localparam int          FAILSAFE_BIT  = 3;
  localparam int          LOST_BIT      = 2;

  localparam logic [15:0] GAIN_RESET    = 16'd2560;
  localparam logic [15:0] OFFSET_RESET  = 16'd875;

  typedef enum logic {
    REG_SCALE_GAIN   = 1'b0,
    REG_SCALE_OFFSET = 1'b1
  } reg_idx_t;

endpackage

[hdl/sbus_frame_decoder.sv]
// ----------------------------------------------------------------------------
// sbus_frame_decoder
// Collects 25-byte S.BUS frames, unpacks the 11-bit channels and emits one
// scaled, rounded and saturated item per channel with the frame flags.
//
//   channel  dir   handshake            payload
//   in_      in    in_valid/in_stall    in_rx_byte
//   out_     out   out_valid/out_stall  index, value, failsafe, lost, last, count
//   cfg      in    APB, pready tied 1   scale_gain @0x0, scale_offset @0x4
//
// One input byte is taken per cycle unless in_stall holds it; a frame's channels
// leave one per cycle from the unpack shift register unless the output stalls.
// The closing byte of a frame is stalled while the previous frame still has
// channels waiting to leave.
// Output items reach the port in the cycle after they leave the unpack register.
// Synchronous active-low reset clears the framer, counters and valid flags.
// ----------------------------------------------------------------------------
module sbus_frame_decoder
  import sfd_pkg::*;
#(
  parameter int NUM_CHANNELS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_rx_byte,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [3:0]  out_channel_index,
  output logic [15:0] out_channel_value,
  output logic        out_failsafe,
  output logic        out_signal_lost,
  output logic        out_last_channel,
  output logic [31:0] out_good_frame_count,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int         EM_W    = CH_W * NUM_CHANNELS;
  localparam logic [3:0] CH_LAST = 4'(NUM_CHANNELS - 1);

  logic [15:0]        gain_r;
  logic signed [15:0] offset_r;

  logic               in_frame_r;
  logic [4:0]         byte_cnt_r;
  logic [PAY_W-1:0]   pay_r;
  logic [7:0]         flags_r;
  logic [31:0]        frames_r;

  logic               em_busy_r;
  logic [3:0]         em_ch_r;
  logic [EM_W-1:0]    em_data_r;
  logic               em_fs_r;
  logic               em_lost_r;
  logic [31:0]        em_cnt_r;

  logic               out_valid_r;
  logic [3:0]         out_ch_r;
  logic [15:0]        out_val_r;
  logic               out_fs_r;
  logic               out_lost_r;
  logic               out_last_r;
  logic [31:0]        out_cnt_r;

  logic               cfg_wr;
  logic               in_acc;
  logic               frame_end;
  logic               out_free;
  logic               em_take;
  logic [CH_W-1:0]    raw;
  logic [26:0]        prod;
  logic signed [28:0] sum;
  logic [16:0]        quo;
  logic [15:0]        val_nxt;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;

  always_comb begin
    case (reg_idx_t'(paddr[2]))
      REG_SCALE_GAIN:   prdata = {16'd0, gain_r};
      REG_SCALE_OFFSET: prdata = {{16{offset_r[15]}}, offset_r};
      default:          prdata = 32'd0;
    endcase
  end

  assign in_stall  = in_frame_r & (byte_cnt_r == CNT_FRAME_END) & em_busy_r;
  assign in_acc    = in_valid & ~in_stall;
  assign frame_end = in_acc & in_frame_r & (byte_cnt_r == CNT_FRAME_END);
  assign out_free  = ~out_valid_r | ~out_stall;
  assign em_take   = em_busy_r & out_free;

  assign raw  = em_data_r[CH_W-1:0];
  assign prod = 27'(raw) * 27'(gain_r);
  assign sum  = $signed({2'b00, prod}) + (29'(offset_r) <<< 12) + 29'sd2048;
  assign quo  = sum[28:12];

  always_comb begin
    if (sum[28]) begin
      val_nxt = 16'd0;
    end else if (quo[16]) begin
      val_nxt = 16'hFFFF;
    end else begin
      val_nxt = quo[15:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r      <= GAIN_RESET;
      offset_r    <= OFFSET_RESET;
      in_frame_r  <= 1'b0;
      byte_cnt_r  <= 5'd0;
      frames_r    <= 32'd0;
      em_busy_r   <= 1'b0;
      em_ch_r     <= 4'd0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_wr) begin
        case (reg_idx_t'(paddr[2]))
          REG_SCALE_GAIN:   gain_r   <= pwdata[15:0];
          REG_SCALE_OFFSET: offset_r <= pwdata[15:0];
          default: ;
        endcase
      end
      if (in_acc) begin
        if (!in_frame_r) begin
          if (in_rx_byte == START_BYTE) begin
            in_frame_r <= 1'b1;
            byte_cnt_r <= CNT_PAY_FIRST;
          end
        end else if (byte_cnt_r == CNT_FRAME_END) begin
          in_frame_r <= 1'b0;
          byte_cnt_r <= 5'd0;
          frames_r   <= frames_r + 32'd1;
        end else begin
          byte_cnt_r <= byte_cnt_r + 5'd1;
        end
      end
      if (frame_end) begin
        em_busy_r <= 1'b1;
        em_ch_r   <= 4'd0;
      end else if (em_take) begin
        em_ch_r <= em_ch_r + 4'd1;
        if (em_ch_r == CH_LAST) begin
          em_busy_r <= 1'b0;
        end
      end
      if (out_free) begin
        out_valid_r <= em_busy_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && in_frame_r) begin
      if (byte_cnt_r >= CNT_PAY_FIRST && byte_cnt_r <= CNT_PAY_LAST) begin
        pay_r <= {in_rx_byte, pay_r[PAY_W-1:8]};
      end
      if (byte_cnt_r == CNT_FLAGS) begin
        flags_r <= in_rx_byte;
      end
    end
    if (frame_end) begin
      em_data_r <= pay_r[EM_W-1:0];
      em_fs_r   <= flags_r[FAILSAFE_BIT];
      em_lost_r <= flags_r[FAILSAFE_BIT] | flags_r[LOST_BIT];
      em_cnt_r  <= frames_r + 32'd1;
    end else if (em_take) begin
      em_data_r <= em_data_r >> CH_W;
    end
    if (em_take) begin
      out_ch_r   <= em_ch_r;
      out_val_r  <= val_nxt;
      out_fs_r   <= em_fs_r;
      out_lost_r <= em_lost_r;
      out_last_r <= (em_ch_r == CH_LAST);
      out_cnt_r  <= em_cnt_r;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_channel_index    = out_ch_r;
  assign out_channel_value    = out_val_r;
  assign out_failsafe         = out_fs_r;
  assign out_signal_lost      = out_lost_r;
  assign out_last_channel     = out_last_r;
  assign out_good_frame_count = out_cnt_r;

  a_frame_starts_burst: assert property (@(posedge clk) disable iff (!rst_n)
    frame_end |=> em_busy_r && em_ch_r == 4'd0)
    else $error("frame end did not start a channel burst");

  a_stall_only_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> em_busy_r && in_frame_r)
    else $error("input stalled with no burst pending");

  a_ch_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    em_busy_r |-> em_ch_r <= CH_LAST)
    else $error("channel counter out of range");

  a_last_marks_top: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_last_r |-> out_ch_r == CH_LAST)
    else $error("last flag on wrong channel");

  a_byte_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    byte_cnt_r <= CNT_FRAME_END && (in_frame_r || byte_cnt_r == 5'd0))
    else $error("byte counter out of range");

endmodule
